FILE: src/vrot_pkg.sv
// vrot_pkg: shared types, constants and saturation helper for the vertex
// Euler rotation unit. No dependencies.
`timescale 1ns / 1ps

package vrot_pkg;

   localparam int COORD_W        = 32;
   localparam int TRIG_W         = 16;
   localparam int TRIG_FRAC_BITS = 14;
   // coord * (negated) trig, trig side one bit wider for -(-32768)
   localparam int PROD_W         = COORD_W + TRIG_W + 1;
   localparam int WIDE_W         = PROD_W + 1;
   localparam int CSR_COUNT      = 6;
   localparam int CSR_IDX_W      = $clog2(CSR_COUNT);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [TRIG_W-1:0]  trig_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;

   localparam trig_type TRIG_ONE  = trig_type'(1 << TRIG_FRAC_BITS);
   localparam trig_type TRIG_ZERO = '0;

   localparam wide_type WIDE_MAX = {{(WIDE_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
   localparam wide_type WIDE_MIN = {{(WIDE_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIN_X = 3'd0,
      CSR_COS_X = 3'd1,
      CSR_SIN_Y = 3'd2,
      CSR_COS_Y = 3'd3,
      CSR_SIN_Z = 3'd4,
      CSR_COS_Z = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic      op;
      coord_type vertex_x;
      coord_type vertex_y;
      coord_type vertex_z;
      coord_type pivot_x;
      coord_type pivot_y;
      coord_type pivot_z;
   } req_payload_type;

   typedef struct packed {
      coord_type rotated_x;
      coord_type rotated_y;
      coord_type rotated_z;
   } rsp_payload_type;

   // One vertex in flight: pivot-relative coordinates plus the pivot.
   typedef struct packed {
      logic      op;
      coord_type x;
      coord_type y;
      coord_type z;
      coord_type px;
      coord_type py;
      coord_type pz;
   } beat_type;

   typedef struct packed {
      trig_type sin_v;
      trig_type cos_v;
   } trig_pair_type;

   typedef struct packed {
      trig_pair_type about_x;
      trig_pair_type about_y;
      trig_pair_type about_z;
   } trig_set_type;

   function automatic coord_type sat_wide(input wide_type v);
      coord_type r;
      if (v > WIDE_MAX) begin
         r = WIDE_MAX[COORD_W-1:0];
      end else if (v < WIDE_MIN) begin
         r = WIDE_MIN[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: src/vrot_csr.sv
// vrot_csr: sine/cosine register file, one pair per axis.
// Depends on vrot_pkg.
`timescale 1ns / 1ps

module vrot_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [vrot_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vrot_pkg::TRIG_W-1:0]    csr_wdata,
   output vrot_pkg::trig_set_type         trig
);
   import vrot_pkg::*;

   trig_set_type trig_ff, trig_in;

   always_comb begin
      trig_in = trig_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SIN_X: trig_in.about_x.sin_v = trig_type'(csr_wdata);
            CSR_COS_X: trig_in.about_x.cos_v = trig_type'(csr_wdata);
            CSR_SIN_Y: trig_in.about_y.sin_v = trig_type'(csr_wdata);
            CSR_COS_Y: trig_in.about_y.cos_v = trig_type'(csr_wdata);
            CSR_SIN_Z: trig_in.about_z.sin_v = trig_type'(csr_wdata);
            CSR_COS_Z: trig_in.about_z.cos_v = trig_type'(csr_wdata);
            default:   trig_in = trig_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff <= '{about_x: '{sin_v: TRIG_ZERO, cos_v: TRIG_ONE},
                      about_y: '{sin_v: TRIG_ZERO, cos_v: TRIG_ONE},
                      about_z: '{sin_v: TRIG_ZERO, cos_v: TRIG_ONE}};
      end else begin
         trig_ff <= trig_in;
      end
   end

   assign trig = trig_ff;

endmodule

FILE: src/vrot_rot_cell.sv
// vrot_rot_cell: one planar rotation of the chain, two register stages
// (products, then shift/sum/saturate). Depends on vrot_pkg.
`timescale 1ns / 1ps

module vrot_rot_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  vrot_pkg::beat_type     in_beat,
   input  vrot_pkg::trig_set_type trig,
   input  vrot_pkg::axis_type     fwd_axis,
   input  vrot_pkg::axis_type     rev_axis,
   output logic                   out_valid,
   output vrot_pkg::beat_type     out_beat
);
   import vrot_pkg::*;

   axis_type               axis;
   coord_type              f_val, s_val;
   trig_pair_type          pair;
   logic signed [TRIG_W:0] neg_sn;

   logic     a_valid_ff, a_valid_in;
   beat_type a_beat_ff;
   axis_type a_axis_ff;
   prod_type p_fc_ff, p_fc_in;
   prod_type p_sn_ff, p_sn_in;
   prod_type p_fs_ff, p_fs_in;
   prod_type p_sc_ff, p_sc_in;

   logic     b_valid_ff, b_valid_in;
   beat_type b_beat_ff, b_beat_in;
   coord_type f_rot, s_rot;

   // stage A: pick the pair and trig for this axis, multiply
   always_comb begin
      axis = in_beat.op ? rev_axis : fwd_axis;
      case (axis)
         AXIS_X: begin
            f_val = in_beat.z;
            s_val = in_beat.y;
            pair  = trig.about_x;
         end
         AXIS_Y: begin
            f_val = in_beat.x;
            s_val = in_beat.z;
            pair  = trig.about_y;
         end
         AXIS_Z: begin
            f_val = in_beat.x;
            s_val = in_beat.y;
            pair  = trig.about_z;
         end
         default: begin
            f_val = in_beat.x;
            s_val = in_beat.y;
            pair  = trig.about_z;
         end
      endcase
      neg_sn  = -{pair.sin_v[TRIG_W-1], pair.sin_v};
      p_fc_in = PROD_W'(f_val) * PROD_W'(pair.cos_v);
      p_sn_in = PROD_W'(s_val) * PROD_W'(neg_sn);
      p_fs_in = PROD_W'(f_val) * PROD_W'(pair.sin_v);
      p_sc_in = PROD_W'(s_val) * PROD_W'(pair.cos_v);
      a_valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_beat_ff <= in_beat;
         a_axis_ff <= axis;
         p_fc_ff   <= p_fc_in;
         p_sn_ff   <= p_sn_in;
         p_fs_ff   <= p_fs_in;
         p_sc_ff   <= p_sc_in;
      end
   end

   // stage B: floor each product on its own, sum exactly, saturate
   always_comb begin
      f_rot = sat_wide(WIDE_W'(p_fc_ff >>> TRIG_FRAC_BITS)
                     + WIDE_W'(p_sn_ff >>> TRIG_FRAC_BITS));
      s_rot = sat_wide(WIDE_W'(p_fs_ff >>> TRIG_FRAC_BITS)
                     + WIDE_W'(p_sc_ff >>> TRIG_FRAC_BITS));
      b_beat_in = a_beat_ff;
      case (a_axis_ff)
         AXIS_X: begin
            b_beat_in.z = f_rot;
            b_beat_in.y = s_rot;
         end
         AXIS_Y: begin
            b_beat_in.x = f_rot;
            b_beat_in.z = s_rot;
         end
         AXIS_Z: begin
            b_beat_in.x = f_rot;
            b_beat_in.y = s_rot;
         end
         default: begin
            b_beat_in = a_beat_ff;
         end
      endcase
      b_valid_in = a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_beat_ff <= b_beat_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_beat  = b_beat_ff;

   a_fill: assert property (@(posedge clock) disable iff (reset)
      advance && in_valid |=> a_valid_ff)
      else $error("rot cell: beat lost entering product stage");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      advance && a_valid_ff |=> b_valid_ff && b_beat_ff.op == $past(a_beat_ff.op))
      else $error("rot cell: beat lost leaving product stage");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(b_valid_ff) && $stable(b_beat_ff) && $stable(a_valid_ff))
      else $error("rot cell: stage moved while pipeline held");

endmodule

FILE: src/vertex_euler_rotation_unit.sv
// vertex_euler_rotation_unit: top level; pivot subtract, three rotation cells,
// pivot add, output register. Depends on vrot_pkg, vrot_csr, vrot_rot_cell.
//
//   channel | ports                           | direction
//   --------+---------------------------------+-----------------------------
//   req     | req_valid, req_stall, req_payload | vertex + pivot + op in
//   rsp     | rsp_valid, rsp_stall, rsp_payload | rotated vertex out
//   csr     | csr_we, csr_index, csr_wdata      | sin/cos writes, no read
//
// One beat in and one out per cycle unless held (below); registered at pivot
// subtract, each cell's two stages, and pivot add into the output register.
// The whole chain advances together; it holds only while a result sits in
// the output register with rsp_stall high, and req_stall follows that.
// Synchronous reset clears the valid chain and sets sin 0, cos 1.0 per axis.
`timescale 1ns / 1ps

module vertex_euler_rotation_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  vrot_pkg::req_payload_type      req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output vrot_pkg::rsp_payload_type      rsp_payload,
   input  logic                           csr_we,
   input  logic [vrot_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vrot_pkg::TRIG_W-1:0]    csr_wdata
);
   import vrot_pkg::*;

   localparam int N_CELLS = 3;

   trig_set_type trig;
   logic         advance;

   logic     s0_valid_ff;
   beat_type s0_beat_ff, s0_beat_in;

   logic     cell_valid [N_CELLS+1];
   beat_type cell_beat  [N_CELLS+1];

   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;

   // forward X,Y,Z; reverse Z,Y,X
   localparam axis_type FWD_AXIS [N_CELLS] = '{AXIS_X, AXIS_Y, AXIS_Z};
   localparam axis_type REV_AXIS [N_CELLS] = '{AXIS_Z, AXIS_Y, AXIS_X};

   vrot_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .trig      (trig)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      s0_beat_in.op = req_payload.op;
      s0_beat_in.px = req_payload.pivot_x;
      s0_beat_in.py = req_payload.pivot_y;
      s0_beat_in.pz = req_payload.pivot_z;
      s0_beat_in.x  = sat_wide(WIDE_W'(req_payload.vertex_x) - WIDE_W'(req_payload.pivot_x));
      s0_beat_in.y  = sat_wide(WIDE_W'(req_payload.vertex_y) - WIDE_W'(req_payload.pivot_y));
      s0_beat_in.z  = sat_wide(WIDE_W'(req_payload.vertex_z) - WIDE_W'(req_payload.pivot_z));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_beat_ff <= s0_beat_in;
      end
   end

   assign cell_valid[0] = s0_valid_ff;
   assign cell_beat[0]  = s0_beat_ff;

   for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
      vrot_rot_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (cell_valid[i]),
         .in_beat   (cell_beat[i]),
         .trig      (trig),
         .fwd_axis  (FWD_AXIS[i]),
         .rev_axis  (REV_AXIS[i]),
         .out_valid (cell_valid[i+1]),
         .out_beat  (cell_beat[i+1])
      );
   end

   always_comb begin
      rsp_in.rotated_x = sat_wide(WIDE_W'(cell_beat[N_CELLS].x) + WIDE_W'(cell_beat[N_CELLS].px));
      rsp_in.rotated_y = sat_wide(WIDE_W'(cell_beat[N_CELLS].y) + WIDE_W'(cell_beat[N_CELLS].py));
      rsp_in.rotated_z = sat_wide(WIDE_W'(cell_beat[N_CELLS].z) + WIDE_W'(cell_beat[N_CELLS].pz));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= cell_valid[N_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s0_valid_ff)
      else $error("accepted request beat did not enter the chain");

   a_leave: assert property (@(posedge clock) disable iff (reset)
      advance && cell_valid[N_CELLS] |=> rsp_valid_ff)
      else $error("finished beat lost before the output register");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s0_valid_ff)
      else $error("valid chain not cleared by reset");

endmodule
